>>> rtl/ctq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared widths, constants and register indexes for the capacitive touch
// qualifier.
// ----------------------------------------------------------------------------
package ctq_pkg;

    // Default sizing of the channel stores and the vote window.
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int WINDOW_DEF       = 4;

    // Field widths of the streams.
    localparam int CH_W     = 3;
    localparam int RAW_W    = 10;
    localparam int DELTA_W  = 12;
    localparam int THR_W    = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HEAD_CHANNEL        = 3'd0,
        REG_HEAD_THRESHOLD      = 3'd1,
        REG_SENSITIVE_CHANNEL   = 3'd2,
        REG_SENSITIVE_THRESHOLD = 3'd3,
        REG_DEFAULT_THRESHOLD   = 3'd4
    } cfg_reg_t;

    // Register reset values.
    localparam logic [CH_W-1:0]  HEAD_CHANNEL_RST        = 3'd0;
    localparam logic [THR_W-1:0] HEAD_THRESHOLD_RST      = 6'd6;
    localparam logic [CH_W-1:0]  SENSITIVE_CHANNEL_RST   = 3'd3;
    localparam logic [THR_W-1:0] SENSITIVE_THRESHOLD_RST = 6'd20;
    localparam logic [THR_W-1:0] DEFAULT_THRESHOLD_RST   = 6'd15;

    // Processing constants.
    localparam int SWEEP_W = 10;
    localparam logic [RAW_W-1:0]   SKIP_BELOW      = 10'd2;
    localparam logic [SWEEP_W-1:0] BASELINE_AFTER  = 10'd5;
    localparam logic [RAW_W-1:0]   BASELINE_MARGIN = 10'd3;
    localparam logic [SWEEP_W-1:0] SWEEP_MAX       = 10'd1000;

endpackage

>>> rtl/capacitive_touch_qualifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacitive_touch_qualifier_core
// Per-channel smoothing, baseline capture and majority-vote touch decision.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while decisions are taken, and
// returns one decision beat per sample, in order. A sample's entry in the
// state memory is read at the edge that accepts it. The update and write-back
// follow in the update stage, which loads the decision into the output register
// as it lets the beat go; an untaken output stalls it. Throughput is one beat per
// cycle, set by the single read port and single write port of that memory;
// a back-to-back sample on the same channel picks up the fresh entry through
// a forwarding path. The memory holds, per channel, the smoothed value, the
// baseline and the sign bits of the last WINDOW deltas. Per-entry valid bits
// make every entry read as zero after reset, so no clearing pass is needed.
// The sweep counters advance on each beat that carries s_tlast.
// ----------------------------------------------------------------------------
module capacitive_touch_qualifier_core #(
    parameter int NUM_CHANNELS = ctq_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW       = ctq_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Sample stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctq_pkg::S_DATA_W-1:0]   s_tdata,  // [2:0] channel, [12:3] raw_sample
    input  logic                           s_tlast,  // end_of_sweep

    // Decision stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] out_channel, [3] touched, [4] decided, [14:5] smoothed, [26:15] delta
    output logic [ctq_pkg::M_DATA_W-1:0]   m_tdata,

    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  logic [ctq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ctq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ctq_pkg::*;

    localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW      = $clog2(WINDOW);
    localparam int FW      = $clog2(WINDOW + 1);
    localparam int HALF    = WINDOW / 2;
    localparam int WORD_W  = 2 * RAW_W + WINDOW;
    localparam int CHX_W   = 5;
    localparam logic [CHX_W-1:0] NUM_CH_X   = CHX_W'(NUM_CHANNELS);
    localparam logic [PW-1:0]    POS_LAST   = PW'(WINDOW - 1);
    localparam logic [FW-1:0]    FILL_FULL  = FW'(WINDOW);
    localparam logic [FW-1:0]    FILL_DEC   = FW'(WINDOW - 1);

    // Configuration registers.
    logic [CH_W-1:0]  head_ch_reg;
    logic [THR_W-1:0] head_thr_reg;
    logic [CH_W-1:0]  sens_ch_reg;
    logic [THR_W-1:0] sens_thr_reg;
    logic [THR_W-1:0] def_thr_reg;

    // Sweep counters.
    logic [SWEEP_W-1:0] sweep_reg;
    logic [FW-1:0]      fill_reg;
    logic [PW-1:0]      pos_reg;

    // State memory and its valid bits.
    logic [WORD_W-1:0]       mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;

    // Update stage.
    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic [RAW_W-1:0]  s1_raw_reg;
    logic              s1_eos_reg;
    logic              s1_inr_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    // Output register.
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // Input decode.
    logic [CH_W-1:0]  in_ch;
    logic [RAW_W-1:0] in_raw;
    logic [CHX_W-1:0] in_ch_x;
    logic [AW-1:0]    in_addr;
    logic             in_inr;
    logic             s_fire;
    logic             s1_adv;

    assign in_ch   = s_tdata[CH_W-1:0];
    assign in_raw  = s_tdata[CH_W +: RAW_W];
    assign in_ch_x = CHX_W'(in_ch);
    assign in_addr = in_ch_x[AW-1:0];
    assign in_inr  = in_ch_x < NUM_CH_X;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    // Update logic for the beat in the update stage.
    logic [WORD_W-1:0]  old_word;
    logic [RAW_W-1:0]   old_smooth;
    logic [RAW_W-1:0]   old_base;
    logic [WINDOW-1:0]  old_win;
    logic               take;
    logic [RAW_W:0]     sum_avg;
    logic [RAW_W+1:0]   sum_3;
    logic [RAW_W-1:0]   s_new;
    logic [THR_W-1:0]   thr;
    logic [DELTA_W-1:0] delta;
    logic [WINDOW-1:0]  win_new;
    logic [RAW_W-1:0]   base_new;
    logic [WORD_W-1:0]  wr_word;
    logic               wr_en;
    logic               decided;
    logic               touched;
    logic [RAW_W-1:0]   smooth_out;
    logic [DELTA_W-1:0] delta_out;

    always_comb begin
        if (fwd_hit_reg) begin
            old_word = fwd_word_reg;
        end else if (rd_valid_reg) begin
            old_word = rd_word_reg;
        end else begin
            old_word = '0;
        end
        old_smooth = old_word[RAW_W-1:0];
        old_base   = old_word[2*RAW_W-1:RAW_W];
        old_win    = old_word[WORD_W-1:2*RAW_W];

        take = s1_inr_reg && (s1_raw_reg >= SKIP_BELOW);

        // Smoothing: raw as is in sweep 0, averaged in sweep 1, then 1/4 weight.
        sum_avg = {1'b0, s1_raw_reg} + {1'b0, old_smooth};
        sum_3   = {2'b00, s1_raw_reg} + {2'b00, old_smooth} + {1'b0, old_smooth, 1'b0};
        if (sweep_reg == '0) begin
            s_new = s1_raw_reg;
        end else if (sweep_reg == SWEEP_W'(1)) begin
            s_new = sum_avg[RAW_W:1];
        end else begin
            s_new = sum_3[RAW_W+1:2];
        end

        // Threshold choice; the head channel wins over the sensitive one.
        if (s1_ch_reg == head_ch_reg) begin
            thr = head_thr_reg;
        end else if (s1_ch_reg == sens_ch_reg) begin
            thr = sens_thr_reg;
        end else begin
            thr = def_thr_reg;
        end

        // Delta against the trip level, wrapped to twelve bits.
        delta = DELTA_W'(s1_raw_reg) + DELTA_W'(thr) - DELTA_W'(old_base);

        win_new          = old_win;
        win_new[pos_reg] = delta[DELTA_W-1];

        // Baseline capture once enough sweeps have gone by.
        base_new = old_base;
        if ((sweep_reg > BASELINE_AFTER) && (old_base == '0)) begin
            base_new = (s_new > BASELINE_MARGIN) ? (s_new - BASELINE_MARGIN) : '0;
        end

        wr_word = {win_new, base_new, s_new};
        wr_en   = s1_adv && take;

        // Majority vote over the window.
        decided = fill_reg >= FILL_DEC;
        touched = s1_inr_reg && decided &&
                  ($countones(take ? win_new : old_win) > HALF);

        if (!s1_inr_reg) begin
            smooth_out = '0;
        end else if (take) begin
            smooth_out = s_new;
        end else begin
            smooth_out = old_smooth;
        end
        delta_out = take ? delta : '0;
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ch_reg  <= HEAD_CHANNEL_RST;
            head_thr_reg <= HEAD_THRESHOLD_RST;
            sens_ch_reg  <= SENSITIVE_CHANNEL_RST;
            sens_thr_reg <= SENSITIVE_THRESHOLD_RST;
            def_thr_reg  <= DEFAULT_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HEAD_CHANNEL:        head_ch_reg  <= cfg_wdata[CH_W-1:0];
                REG_HEAD_THRESHOLD:      head_thr_reg <= cfg_wdata;
                REG_SENSITIVE_CHANNEL:   sens_ch_reg  <= cfg_wdata[CH_W-1:0];
                REG_SENSITIVE_THRESHOLD: sens_thr_reg <= cfg_wdata;
                REG_DEFAULT_THRESHOLD:   def_thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sweep counters advance after the last beat of a sweep is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
        end else if (s1_adv && s1_eos_reg) begin
            if (sweep_reg < SWEEP_MAX) begin
                sweep_reg <= sweep_reg + SWEEP_W'(1);
            end
            if (fill_reg < FILL_FULL) begin
                fill_reg <= fill_reg + FW'(1);
            end
            pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
        end
    end

    // State memory: one read on accept, one write-back from the update stage.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_addr_reg] <= wr_word;
        end
        if (s_fire && in_inr) begin
            rd_word_reg <= mem[in_addr];
        end
    end

    // Valid bits, read flag and forwarding of a same-channel write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (s_fire) begin
                rd_valid_reg <= in_inr && valid_reg[in_addr];
                fwd_hit_reg  <= in_inr && wr_en && (s1_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_word_reg <= wr_word;
        end
    end

    // Update stage occupancy and payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_ch_reg   <= in_ch;
            s1_raw_reg  <= in_raw;
            s1_eos_reg  <= s_tlast;
            s1_inr_reg  <= in_inr;
            s1_addr_reg <= in_addr;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {5'b0, delta_out, smooth_out, decided, touched, s1_ch_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capacitive touch qualifier core.
// ----------------------------------------------------------------------------
// Sample beats go in on the slave stream and decision beats come back on the
// master stream, one per sample. An in-bench predictor tracks each channel's
// smoothed value, baseline and delta history. It also tracks the sweep
// counters and the threshold registers, and it queues the decision expected
// for every accepted sample. A short opening sequence walks the first sweeps
// from reset. It covers skipped samples, baseline capture and a first touch.
// Random phases under several threshold settings follow. A final run of
// one-sample sweeps advances the sweep counters on every beat. Both
// streams see random gaps and stalls, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import ctq_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int WIN         = WINDOW_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 70;
    localparam int SOAK_ITEMS  = 150;
    localparam int HOLD_CYCLES = 80;

    // Decision fields in m_tdata order, lowest bits last in the list.
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [RAW_W-1:0]   smoothed;
        logic               decided;
        logic               touched;
        logic [CH_W-1:0]    channel;
    } decision_t;

    typedef struct {
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        logic             last;
        bit               typed;
        decision_t        want;
    } sample_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the registers and per-channel state.
    logic [CH_W-1:0]    head_ch;
    logic [THR_W-1:0]   head_thr;
    logic [CH_W-1:0]    sens_ch;
    logic [THR_W-1:0]   sens_thr;
    logic [THR_W-1:0]   dflt_thr;
    logic [RAW_W-1:0]   level_mem [NCH];
    logic [RAW_W-1:0]   floor_mem [NCH];
    logic [DELTA_W-1:0] delta_hist [NCH][WIN];
    int unsigned        sweeps_seen;
    int unsigned        fill_cnt;
    int unsigned        hist_pos;

    decision_t   pending_decisions[$];
    sample_row_t opening_rows[$];
    int          rest_level [NCH];
    int          touch_left [NCH];
    int          items_sent    = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    bit          stall_request = 1'b0;

    capacitive_touch_qualifier_core #(
        .NUM_CHANNELS(NCH),
        .WINDOW      (WIN)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Computes the decision for one sample and advances the predictor state.
    function automatic decision_t predict_decision(input logic [CH_W-1:0] ch,
                                                   input logic [RAW_W-1:0] raw,
                                                   input logic last);
        decision_t        r;
        int unsigned      prev;
        int unsigned      lvl;
        int unsigned      base;
        int unsigned      negs;
        int               trip;
        int               d;
        logic [THR_W-1:0] thr;
        r = '0;
        r.channel = ch;
        r.decided = (fill_cnt + 1 >= WIN);
        if (raw >= SKIP_BELOW) begin
            prev = level_mem[ch];
            if (sweeps_seen == 0)
                lvl = raw;
            else if (sweeps_seen == 1)
                lvl = (raw + prev) / 2;
            else
                lvl = (raw + 3 * prev) / 4;
            level_mem[ch] = lvl[RAW_W-1:0];
            // The head channel takes precedence over the sensitive one.
            if (ch == head_ch)
                thr = head_thr;
            else if (ch == sens_ch)
                thr = sens_thr;
            else
                thr = dflt_thr;
            trip = int'(floor_mem[ch]) - int'(thr);
            d = int'(raw) - trip;
            r.delta = d[DELTA_W-1:0];
            delta_hist[ch][hist_pos] = d[DELTA_W-1:0];
            // Baseline is captured once; a capture of zero leaves it unset.
            if (sweeps_seen > BASELINE_AFTER && floor_mem[ch] == '0) begin
                base = (lvl > BASELINE_MARGIN) ? lvl - BASELINE_MARGIN : 0;
                floor_mem[ch] = base[RAW_W-1:0];
            end
        end
        r.smoothed = level_mem[ch];
        negs = 0;
        for (int p = 0; p < WIN; p++)
            if (delta_hist[ch][p][DELTA_W-1])
                negs++;
        r.touched = r.decided && (negs > WIN / 2);
        if (last) begin
            if (sweeps_seen < SWEEP_MAX)
                sweeps_seen++;
            if (fill_cnt < WIN)
                fill_cnt++;
            hist_pos = (hist_pos + 1) % WIN;
        end
        return r;
    endfunction

    function automatic void reset_predictor();
        head_ch     = HEAD_CHANNEL_RST;
        head_thr    = HEAD_THRESHOLD_RST;
        sens_ch     = SENSITIVE_CHANNEL_RST;
        sens_thr    = SENSITIVE_THRESHOLD_RST;
        dflt_thr    = DEFAULT_THRESHOLD_RST;
        sweeps_seen = 0;
        fill_cnt    = 0;
        hist_pos    = 0;
        for (int c = 0; c < NCH; c++) begin
            level_mem[c] = '0;
            floor_mem[c] = '0;
            for (int p = 0; p < WIN; p++)
                delta_hist[c][p] = '0;
        end
    endfunction

    function automatic void add_row(input int ch, input int raw, input bit last,
                                    input bit typed, input bit touched, input bit decided,
                                    input int smoothed, input int delta);
        sample_row_t row;
        row.ch                = CH_W'(ch);
        row.raw               = RAW_W'(raw);
        row.last              = last;
        row.typed             = typed;
        row.want.channel      = CH_W'(ch);
        row.want.touched      = touched;
        row.want.decided      = decided;
        row.want.smoothed     = RAW_W'(smoothed);
        row.want.delta        = DELTA_W'(delta);
        opening_rows.push_back(row);
    endfunction

    // Sender gap: mostly back to back or short, a few long, with bursts of no gap.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Sample around the channel's rest level, dipping during a touch episode.
    function automatic logic [RAW_W-1:0] pick_raw(input int ch);
        int r;
        int v;
        int dip;
        int noise;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            v = $urandom_range(0, 1);
        end else if (r < 12) begin
            v = $urandom_range(0, 1023);
        end else if (touch_left[ch] > 0 || r < 20) begin
            dip = $urandom_range(20, 300);
            v = rest_level[ch] - dip;
        end else begin
            noise = $urandom_range(0, 8);
            v = rest_level[ch] + noise - 4;
        end
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[RAW_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one sample beat and queues its decision once the beat is taken.
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
                               input logic last, input bit typed, input decision_t want);
        int        gap;
        decision_t pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - CH_W - RAW_W){1'b0}}, raw, ch};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_decision(ch, raw, last);
        pending_decisions.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // One sweep in channel order, some channels left out, tlast on the final one.
    task automatic send_sweep();
        int last_ch;
        int c;
        last_ch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NCH - 1) : NCH - 1;
        for (c = 0; c <= last_ch; c++)
            if (c == last_ch || $urandom_range(0, 6) != 0)
                send_sample(CH_W'(c), pick_raw(c), c == last_ch, 1'b0, '0);
        // Touch episodes span a few sweeps so the vote can pick them up.
        for (c = 0; c < NCH; c++)
            if (touch_left[c] > 0)
                touch_left[c]--;
            else if ($urandom_range(0, 7) == 0)
                touch_left[c] = $urandom_range(2, 6);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_HEAD_CHANNEL:        head_ch  = val[CH_W-1:0];
            REG_HEAD_THRESHOLD:      head_thr = val[THR_W-1:0];
            REG_SENSITIVE_CHANNEL:   sens_ch  = val[CH_W-1:0];
            REG_SENSITIVE_THRESHOLD: sens_thr = val[THR_W-1:0];
            REG_DEFAULT_THRESHOLD:   dflt_thr = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Registers change only with the core idle.
    task automatic program_regs(input logic [CH_W-1:0] hc, input logic [THR_W-1:0] ht,
                                input logic [CH_W-1:0] sc, input logic [THR_W-1:0] st,
                                input logic [THR_W-1:0] dt);
        drain_results();
        write_reg(REG_HEAD_CHANNEL, CFG_DATA_W'(hc));
        write_reg(REG_HEAD_THRESHOLD, CFG_DATA_W'(ht));
        write_reg(REG_SENSITIVE_CHANNEL, CFG_DATA_W'(sc));
        write_reg(REG_SENSITIVE_THRESHOLD, CFG_DATA_W'(st));
        write_reg(REG_DEFAULT_THRESHOLD, CFG_DATA_W'(dt));
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin : ready_pattern
        int r;
        int n;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (stall_request) begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                n = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 8);
                end else if (r < 85) begin
                    m_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else if (r < 95) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(20, 50);
                end else begin
                    m_tready <= 1'b0;
                    n = $urandom_range(8, 30);
                end
            end
            repeat (n) @(posedge aclk);
        end
    end

    // Compare each decision beat with the oldest queued expectation.
    always @(posedge aclk) begin : check_beats
        decision_t got;
        decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(decision_t)-1:0];
            if (pending_decisions.size() == 0) begin
                report_mismatch("unexpected beat, channel", got.channel, 0);
            end else begin
                want = pending_decisions.pop_front();
                if (got.channel !== want.channel)
                    report_mismatch("out_channel", got.channel, want.channel);
                if (got.touched !== want.touched)
                    report_mismatch("touched", got.touched, want.touched);
                if (got.decided !== want.decided)
                    report_mismatch("decided", got.decided, want.decided);
                if (got.smoothed !== want.smoothed)
                    report_mismatch("smoothed", got.smoothed, want.smoothed);
                if (got.delta !== want.delta)
                    report_mismatch("delta", got.delta, want.delta);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int  ph;
        int  start;
        int  c;
        bit  hold_done;
        bit  paused;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_HEAD_CHANNEL;
        cfg_wdata <= '0;
        hold_done = 1'b0;
        paused    = 1'b0;
        reset_predictor();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Opening sweeps with reset thresholds. Sweep 0: raw taken as is,
        // skipped samples report zero, extremes of raw and channel.
        add_row(0, 1023, 0, 1, 0, 0, 1023, 1029);
        add_row(1, 0,    0, 1, 0, 0, 0,    0);
        add_row(2, 1,    0, 1, 0, 0, 0,    0);
        add_row(3, 2,    0, 1, 0, 0, 2,    22);
        add_row(5, 2,    0, 1, 0, 0, 2,    17);
        add_row(7, 1023, 1, 1, 0, 0, 1023, 1038);
        // Sweep 1 averages; a skipped sample keeps the stored value.
        add_row(0, 2,    0, 0, 0, 0, 0,    0);
        add_row(5, 2,    0, 0, 0, 0, 0,    0);
        add_row(7, 0,    1, 1, 0, 0, 1023, 0);
        // Sweeps 2 to 5: quarter-weight smoothing, window fills up.
        add_row(0, 1023, 0, 0, 0, 0, 0,    0);
        add_row(5, 3,    1, 0, 0, 0, 0,    0);
        add_row(0, 1023, 0, 0, 0, 0, 0,    0);
        add_row(3, 1023, 1, 0, 0, 0, 0,    0);
        add_row(0, 1023, 0, 0, 0, 0, 0,    0);
        add_row(5, 2,    1, 0, 0, 0, 0,    0);
        add_row(6, 1023, 1, 0, 0, 0, 0,    0);
        // Sweep 6: baseline capture on channel 0, channel 5 stays unset.
        add_row(0, 1023, 0, 0, 0, 0, 0,    0);
        add_row(5, 2,    0, 0, 0, 0, 0,    0);
        add_row(0, 0,    1, 0, 0, 0, 0,    0);
        // Channel 0 drops well under its trip level until the vote turns.
        add_row(0, 2,    1, 0, 0, 0, 0,    0);
        add_row(0, 2,    1, 0, 0, 0, 0,    0);
        add_row(0, 2,    1, 0, 0, 0, 0,    0);
        add_row(0, 1023, 1, 0, 0, 0, 0,    0);
        foreach (opening_rows[i])
            send_sample(opening_rows[i].ch, opening_rows[i].raw, opening_rows[i].last,
                        opening_rows[i].typed, opening_rows[i].want);

        // Rest levels follow a captured baseline where there is one.
        for (c = 0; c < NCH; c++) begin
            touch_left[c] = 0;
            if (floor_mem[c] != '0)
                rest_level[c] = int'(floor_mem[c]);
            else if ($urandom_range(0, 9) == 0)
                rest_level[c] = $urandom_range(2, 5);
            else if ($urandom_range(0, 9) == 0)
                rest_level[c] = $urandom_range(1000, 1023);
            else
                rest_level[c] = $urandom_range(40, 1000);
        end

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                1: program_regs(3'd7, 6'd63, 3'd0, 6'd0, 6'd0);
                2: program_regs(3'd4, 6'd0, 3'd4, 6'd63, 6'd63);
                3, 4: program_regs(CH_W'($urandom_range(0, 7)), THR_W'($urandom_range(0, 63)),
                                   CH_W'($urandom_range(0, 7)), THR_W'($urandom_range(0, 63)),
                                   THR_W'($urandom_range(0, 63)));
                5: program_regs(3'd3, 6'd63, 3'd3, 6'd0, 6'd32);
                default: ;
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                // Long receiver hold-off while samples keep coming.
                if (ph == 1 && !hold_done && items_sent - start >= PHASE_ITEMS / 2) begin
                    stall_request = 1'b1;
                    hold_done = 1'b1;
                end
                // Sender pauses until every decision is back.
                if (ph == 2 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) != 0)
                    send_sweep();
                else
                    send_sample(CH_W'($urandom_range(0, NCH - 1)),
                                RAW_W'($urandom_range(0, 1023)),
                                $urandom_range(0, 3) == 0, 1'b0, '0);
            end
        end

        // One-sample sweeps advance the sweep counters on every beat.
        program_regs(CH_W'($urandom_range(0, 7)), THR_W'($urandom_range(0, 63)),
                     CH_W'($urandom_range(0, 7)), THR_W'($urandom_range(0, 63)),
                     THR_W'($urandom_range(0, 63)));
        repeat (SOAK_ITEMS) begin
            c = $urandom_range(0, NCH - 1);
            send_sample(CH_W'(c), pick_raw(c), 1'b1, 1'b0, '0);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
